>>> design/csp_pkg.sv
// Package for color_segment_projection: widths, types and shared constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package csp_pkg;
  localparam int unsigned NumLanes  = 4;
  localparam int unsigned CompW     = 8;
  localparam int unsigned DiffW     = 9;    // signed component difference
  localparam int unsigned SqW       = 18;   // t*t per lane
  localparam int unsigned LenW      = 19;   // sum of four squares
  localparam int unsigned DotW      = 20;   // signed sum of four products
  localparam int unsigned PosW      = 17;
  localparam int unsigned DistW     = 17;
  localparam int unsigned ResW      = 26;   // signed residual u*65536 - pos*t
  localparam int unsigned RsqW      = 50;   // squared residual magnitude
  localparam int unsigned SumW      = 52;
  localparam int unsigned RadW      = 36;   // sum >> 16
  localparam int unsigned QuoW      = 16;   // quotient bits below one
  localparam int unsigned RootW     = 18;   // root of RadW bits
  localparam int unsigned Latency   = 42;   // request to result, in cycles
  localparam logic [PosW-1:0] PosOne = 17'h10000;

  localparam logic [1:0] RegLow = 2'd0;
  localparam logic [1:0] RegHigh = 2'd1;
  localparam logic [1:0] RegMinLen = 2'd2;

  typedef logic [CompW-1:0] comp_t;
  typedef logic signed [DiffW-1:0] diff_t;
endpackage
`default_nettype wire

>>> design/csp_lane.sv
// One color component lane: differences, squares and dot terms.
// Depends on csp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module csp_lane (
  input  wire logic                  clk,
  input  wire csp_pkg::comp_t        color,
  input  wire csp_pkg::comp_t        lo,
  input  wire csp_pkg::comp_t        hi,
  output csp_pkg::diff_t             t_r,
  output csp_pkg::diff_t             u_r,
  output logic [csp_pkg::SqW-1:0]    tt_r,
  output logic signed [csp_pkg::SqW-1:0] tu_r
);
  import csp_pkg::*;
  diff_t t_nxt, u_nxt;
  assign t_nxt = diff_t'({1'b0, hi}) - diff_t'({1'b0, lo});
  assign u_nxt = diff_t'({1'b0, color}) - diff_t'({1'b0, lo});
  always_ff @(posedge clk) begin
    t_r  <= t_nxt;
    u_r  <= u_nxt;
    // square is never negative, so the 18-bit signed product reads as unsigned
    tt_r <= SqW'(t_nxt * t_nxt);
    tu_r <= SqW'(t_nxt * u_nxt);
  end
endmodule
`default_nettype wire

>>> design/csp_div.sv
// Pipelined restoring divider, one quotient bit per stage, giving the
// Q0.16 fraction dot/len for 0 < dot < len. Depends on csp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module csp_div #(
  parameter int unsigned SideW = 64
) (
  input  wire logic                      clk,
  input  wire logic [csp_pkg::LenW-1:0]  num,
  input  wire logic [csp_pkg::LenW-1:0]  den,
  input  wire logic [SideW-1:0]          side_in,
  output logic [csp_pkg::QuoW-1:0]       quo,
  output logic [SideW-1:0]               side_out
);
  import csp_pkg::*;
  logic [LenW:0]      rem_r  [1:QuoW];
  logic [LenW-1:0]    den_r  [1:QuoW];
  logic [QuoW-1:0]    q_r    [1:QuoW];
  logic [SideW-1:0]   side_r [1:QuoW];
  for (genvar s = 0; s < QuoW; s++) begin : g_stage
    logic [LenW:0]    rem_in;
    logic [LenW-1:0]  den_in;
    logic [QuoW-1:0]  q_in;
    logic [SideW-1:0] side_s;
    logic [LenW+1:0] sh;
    logic [LenW+1:0] df;
    if (s == 0) begin : g_first
      assign rem_in = {1'b0, num};
      assign den_in = den;
      assign q_in   = '0;
      assign side_s = side_in;
    end else begin : g_next
      assign rem_in = rem_r[s];
      assign den_in = den_r[s];
      assign q_in   = q_r[s];
      assign side_s = side_r[s];
    end
    assign sh = {rem_in, 1'b0};
    assign df = sh - {2'b0, den_in};
    always_ff @(posedge clk) begin
      if (!df[LenW+1]) begin
        rem_r[s+1] <= df[LenW:0];
        q_r[s+1]   <= {q_in[QuoW-2:0], 1'b1};
      end else begin
        rem_r[s+1] <= sh[LenW:0];
        q_r[s+1]   <= {q_in[QuoW-2:0], 1'b0};
      end
      den_r[s+1]  <= den_in;
      side_r[s+1] <= side_s;
    end
  end
  assign quo      = q_r[QuoW];
  assign side_out = side_r[QuoW];
endmodule
`default_nettype wire

>>> design/csp_sqrt.sv
// Pipelined integer square root, one result bit per stage.
// Depends on csp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module csp_sqrt #(
  parameter int unsigned SideW = 17
) (
  input  wire logic                      clk,
  input  wire logic [csp_pkg::RadW-1:0]  rad,
  input  wire logic [SideW-1:0]          side_in,
  output logic [csp_pkg::RootW-1:0]      root,
  output logic [SideW-1:0]               side_out
);
  import csp_pkg::*;
  logic [RadW-1:0]  v_r    [1:RootW];
  logic [RootW-1:0] q_r    [1:RootW];
  logic [SideW-1:0] side_r [1:RootW];
  for (genvar s = 0; s < RootW; s++) begin : g_stage
    localparam int unsigned B = RootW - 1 - s;
    logic [RadW-1:0]  v_in;
    logic [RootW-1:0] q_in;
    logic [SideW-1:0] side_s;
    logic [RootW-1:0] trial;
    logic [RadW-1:0]  sq;
    if (s == 0) begin : g_first
      assign v_in   = rad;
      assign q_in   = '0;
      assign side_s = side_in;
    end else begin : g_next
      assign v_in   = v_r[s];
      assign q_in   = q_r[s];
      assign side_s = side_r[s];
    end
    // (q + 2^B)^2 - q^2 = 2^(B+1)q + 4^B
    assign trial = q_in | (RootW'(1) << B);
    assign sq = (RadW'(q_in) << (B + 1)) + (RadW'(1) << (2 * B));
    always_ff @(posedge clk) begin
      if (v_in >= sq) begin
        v_r[s+1] <= v_in - sq;
        q_r[s+1] <= trial;
      end else begin
        v_r[s+1] <= v_in;
        q_r[s+1] <= q_in;
      end
      side_r[s+1] <= side_s;
    end
  end
  assign root     = q_r[RootW];
  assign side_out = side_r[RootW];
endmodule
`default_nettype wire

>>> design/color_segment_projection.sv
// Top level of color_segment_projection: config registers, four lanes,
// merge, divider, residual lanes and root. Depends on csp_pkg and submodules.
// Usage:
//   Write low_color (index 0), high_color (1) and min_length_sq (2) through
//   cfg_we/cfg_index/cfg_data while no request is in flight.
//   Raise start with in_red..in_alpha; busy is always low, so a request is
//   taken every cycle the start line is high.
//   Each request returns one result: out_valid pulses for one cycle with
//   out_position (Q1.16) and out_distance (Q9.8).
//   Pipeline: 1 lane stage, 1 merge, 16 divider stages,
//   1 position, 1 residual, 1 square, 2 sum, 18 root stages, 1 output.
//   Throughput is one request per cycle; every stage is fully pipelined.
//   The receiver cannot stall; results are not held.
//   Reset clears config registers to their defaults and the valid chain.
`timescale 1ns / 1ps
`default_nettype none
module color_segment_projection (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [7:0]  in_red,
  input  wire logic [7:0]  in_green,
  input  wire logic [7:0]  in_blue,
  input  wire logic [7:0]  in_alpha,
  output logic             out_valid,
  output logic [16:0]      out_position,
  output logic [16:0]      out_distance,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  import csp_pkg::*;

  localparam logic [1:0] SelDiv  = 2'd0;
  localparam logic [1:0] SelZero = 2'd1;
  localparam logic [1:0] SelOne  = 2'd2;

  logic [31:0] low_r, high_r;
  logic [SqW-1:0] minlen_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r <= '0;
      high_r <= '1;
      minlen_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegLow:    low_r <= cfg_data;
        RegHigh:   high_r <= cfg_data;
        RegMinLen: minlen_r <= cfg_data[SqW-1:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  logic [Latency-1:0] vld_r;
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else vld_r <= {vld_r[Latency-2:0], start};
  end

  comp_t col [NumLanes];
  assign col[0] = in_red;
  assign col[1] = in_green;
  assign col[2] = in_blue;
  assign col[3] = in_alpha;

  diff_t t1 [NumLanes];
  diff_t u1 [NumLanes];
  logic [SqW-1:0] tt1 [NumLanes];
  logic signed [SqW-1:0] tu1 [NumLanes];
  for (genvar k = 0; k < NumLanes; k++) begin : g_lane
    csp_lane u_lane (
      .clk(clk), .color(col[k]), .lo(low_r[8*k +: 8]), .hi(high_r[8*k +: 8]),
      .t_r(t1[k]), .u_r(u1[k]), .tt_r(tt1[k]), .tu_r(tu1[k])
    );
  end

  // merge: sums and case decision
  logic [LenW-1:0] len2_r;
  logic signed [DotW-1:0] dot2_r;
  logic [1:0] sel2_r;
  logic [8*DiffW-1:0] tu2_r;
  logic [LenW-1:0] len_nxt;
  logic signed [DotW-1:0] dot_nxt;
  always_comb begin
    len_nxt = LenW'(tt1[0]) + LenW'(tt1[1]) + LenW'(tt1[2]) + LenW'(tt1[3]);
    dot_nxt = DotW'(tu1[0]) + DotW'(tu1[1]) + DotW'(tu1[2]) + DotW'(tu1[3]);
  end
  always_ff @(posedge clk) begin
    len2_r <= len_nxt;
    dot2_r <= dot_nxt;
    tu2_r <= {t1[3], t1[2], t1[1], t1[0], u1[3], u1[2], u1[1], u1[0]};
    if (len_nxt <= LenW'(minlen_r) || dot_nxt <= 0) sel2_r <= SelZero;
    else if (dot_nxt >= DotW'(signed'({1'b0, len_nxt}))) sel2_r <= SelOne;
    else sel2_r <= SelDiv;
  end

  logic [QuoW-1:0] quo;
  logic [8*DiffW+1:0] side3;
  csp_div #(.SideW(8*DiffW + 2)) u_div (
    .clk(clk), .num(len2_r > LenW'(dot2_r) ? LenW'(dot2_r) : '0), .den(len2_r),
    .side_in({sel2_r, tu2_r}), .quo(quo), .side_out(side3)
  );

  logic [PosW-1:0] pos4_r;
  logic [8*DiffW-1:0] tu4_r;
  always_ff @(posedge clk) begin
    tu4_r <= side3[8*DiffW-1:0];
    unique case (side3[8*DiffW +: 2])
      SelZero: pos4_r <= '0;
      SelOne:  pos4_r <= PosOne;
      default: pos4_r <= {1'b0, quo};
    endcase
  end

  // residual lanes
  logic [ResW-1:0] rabs5_r [NumLanes];
  logic [RsqW-1:0] sq6_r [NumLanes];
  logic [PosW-1:0] pos5_r, pos6_r, pos7_r, pos8_r;
  for (genvar k = 0; k < NumLanes; k++) begin : g_res
    diff_t tk, uk;
    logic signed [ResW-1:0] r;
    assign tk = tu4_r[DiffW*(k+4) +: DiffW];
    assign uk = tu4_r[DiffW*k +: DiffW];
    assign r = (ResW'(uk) <<< 16) - ResW'(signed'({1'b0, pos4_r}) * tk);
    always_ff @(posedge clk) begin
      rabs5_r[k] <= ResW'(r[ResW-1] ? -r : r);
      sq6_r[k] <= RsqW'(rabs5_r[k] * rabs5_r[k]);
    end
  end
  logic [SumW-1:0] sa7_r, sb7_r, sum8_r;
  always_ff @(posedge clk) begin
    pos5_r <= pos4_r;
    pos6_r <= pos5_r;
    pos7_r <= pos6_r;
    pos8_r <= pos7_r;
    sa7_r <= SumW'(sq6_r[0]) + SumW'(sq6_r[1]);
    sb7_r <= SumW'(sq6_r[2]) + SumW'(sq6_r[3]);
    sum8_r <= sa7_r + sb7_r;
  end

  logic [RootW-1:0] root;
  logic [PosW-1:0] posf;
  csp_sqrt #(.SideW(PosW)) u_sqrt (
    .clk(clk), .rad(sum8_r[16 +: RadW]), .side_in(pos8_r),
    .root(root), .side_out(posf)
  );

  always_ff @(posedge clk) begin
    out_position <= posf;
    out_distance <= root[DistW-1:0];
  end
  assign out_valid = vld_r[Latency-1];

`ifndef SYNTH
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_position <= PosOne) else $error("position above one");
  a_sel_legal: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[1] |-> (sel2_r == SelDiv || sel2_r == SelZero || sel2_r == SelOne))
    else $error("bad select");
  a_valid_lat: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[0] |=> vld_r[1]) else $error("valid chain broken");
`endif
endmodule
`default_nettype wire

>>> dv/testbench.sv
// Self-checking bench for color_segment_projection: projects RGBA colors onto
// the configured segment, predicts position/distance in-line. Depends on csp_pkg.
`timescale 1ns / 1ps
module testbench;
  import csp_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [7:0]  in_red, in_green, in_blue, in_alpha;
  logic        out_valid;
  logic [16:0] out_position, out_distance;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  color_segment_projection u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_red(in_red), .in_green(in_green), .in_blue(in_blue), .in_alpha(in_alpha),
    .out_valid(out_valid), .out_position(out_position), .out_distance(out_distance),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  typedef struct packed {
    logic [16:0] position;
    logic [16:0] distance;
  } proj_t;

  localparam int unsigned PipeDepth = 42;
  localparam longint unsigned CycleLimit = 400000;

  // shadow copy of the config registers
  logic [31:0] low_q, high_q;
  logic [17:0] minlen_q;

  proj_t expected_q[$];
  int unsigned errors, checked, sent, seg_count;
  longint unsigned cycles;
  bit idle_on;

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic proj_t project_color(logic [31:0] color);
    longint t[4], u[4];
    longint len_sq, dotp, pos, r;
    longint unsigned sum, m;
    proj_t p;
    len_sq = 0;
    dotp = 0;
    sum = 0;
    for (int k = 0; k < 4; k++) begin
      t[k] = longint'(high_q[8*k +: 8]) - longint'(low_q[8*k +: 8]);
      u[k] = longint'(color[8*k +: 8]) - longint'(low_q[8*k +: 8]);
      len_sq += t[k] * t[k];
      dotp += t[k] * u[k];
    end
    if (len_sq <= longint'(minlen_q) || dotp <= 0) pos = 0;
    else if (dotp >= len_sq) pos = 65536;
    else pos = (dotp * 65536) / len_sq;
    for (int k = 0; k < 4; k++) begin
      r = u[k] * 65536 - pos * t[k];
      m = (r < 0) ? -r : r;
      sum += m * m;
    end
    p.position = pos[16:0];
    p.distance = 17'(isqrt(sum >> 16));
    return p;
  endfunction

  // result checker
  always @(posedge clk) begin
    proj_t e;
    if (rst_n && out_valid) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result pos=%0d dist=%0d", $time, out_position,
                 out_distance);
        errors++;
      end else begin
        e = expected_q.pop_front();
        checked++;
        if (out_position !== e.position) begin
          $display("%0t: position exp=%0d act=%0d", $time, e.position, out_position);
          errors++;
        end
        if (out_distance !== e.distance) begin
          $display("%0t: distance exp=%0d act=%0d", $time, e.distance, out_distance);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILURE");
      $finish;
    end
  end

  // one request; start stays high across back-to-back requests
  task automatic send_color(logic [7:0] r, g, b, a);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    {in_alpha, in_blue, in_green, in_red} <= {a, b, g, r};
    do @(posedge clk); while (busy);
    expected_q.push_back(project_color({a, b, g, r}));
    sent++;
  endtask

  task automatic send_random_color();
    logic [31:0] c;
    c = $urandom;
    send_color(c[7:0], c[15:8], c[23:16], c[31:24]);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (PipeDepth + 4) @(posedge clk);
  endtask

  // cfg_we stays high across consecutive writes; the caller drops it
  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      RegLow:    low_q = data;
      RegHigh:   high_q = data;
      RegMinLen: minlen_q = data[17:0];
      default: ;
    endcase
  endtask

  task automatic set_segment(logic [31:0] lo, logic [31:0] hi, logic [17:0] minlen);
    drain();
    write_reg(RegLow, lo);
    write_reg(RegHigh, hi);
    write_reg(RegMinLen, {14'd0, minlen});
    cfg_we <= 1'b0;
  endtask

  // reset defaults: black to white, endpoints and extremes
  task automatic test_directed();
    send_color(8'h00, 8'h00, 8'h00, 8'h00);
    send_color(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_color(8'h80, 8'h80, 8'h80, 8'h80);
    send_color(8'hFF, 8'h00, 8'hFF, 8'h00);
    send_color(8'h00, 8'hFF, 8'h00, 8'hFF);
    send_color(8'h01, 8'h02, 8'h04, 8'h08);
    // color past the end and before the start
    set_segment(32'h40404040, 32'h80808080, 18'd0);
    send_color(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_color(8'h00, 8'h00, 8'h00, 8'h00);
    send_color(8'h60, 8'h60, 8'h60, 8'h60);
    send_color(8'h40, 8'h80, 8'h40, 8'h80);
    // reversed segment
    set_segment(32'hFFFFFFFF, 32'h00000000, 18'd0);
    send_color(8'h00, 8'h00, 8'h00, 8'h00);
    send_color(8'h10, 8'hF0, 8'h33, 8'hCC);
    // short segment: length squared exactly at the limit, then just above it
    set_segment(32'h00000000, 32'h00000001, 18'd1);
    send_color(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    set_segment(32'h00000000, 32'h00000002, 18'd3);
    send_color(8'h02, 8'h00, 8'h00, 8'h00);
    send_color(8'h01, 8'h00, 8'h00, 8'h00);
    // degenerate segment, and a limit above every possible length
    set_segment(32'h12345678, 32'h12345678, 18'd0);
    send_color(8'h00, 8'hFF, 8'h00, 8'hFF);
    set_segment(32'h00000000, 32'hFFFFFFFF, 18'h3FFFF);
    send_color(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    set_segment(32'h00000000, 32'hFFFFFFFF, 18'd260100);
    send_color(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    set_segment(32'h00000000, 32'hFFFFFFFF, 18'd260099);
    send_color(8'hFF, 8'hFF, 8'hFF, 8'hFF);
  endtask

  // random segments and length limits; colors random or near a corner of the segment's box
  task automatic test_random_segments(int unsigned n_items);
    logic [31:0] lo, hi, c;
    logic [17:0] minlen;
    int unsigned i;
    i = 0;
    while (i < n_items) begin
      lo = $urandom;
      hi = ($urandom_range(0, 4) == 0) ? lo ^ (32'h1 << $urandom_range(0, 31)) : $urandom;
      case ($urandom_range(0, 3))
        0: minlen = 18'd0;
        1: minlen = 18'($urandom_range(0, 260100));
        2: minlen = 18'($urandom_range(0, 50));
        default: minlen = 18'($urandom);
      endcase
      set_segment(lo, hi, minlen);
      seg_count++;
      repeat ($urandom_range(10, 40)) begin
        if ($urandom_range(0, 1) == 0) begin
          send_random_color();
        end else begin
          // a point near a corner of the box spanned by the endpoints
          for (int k = 0; k < 4; k++)
            c[8*k +: 8] = ($urandom_range(0, 1) ? lo[8*k +: 8] : hi[8*k +: 8])
                          + 8'($urandom_range(0, 6)) - 8'd3;
          send_color(c[7:0], c[15:8], c[23:16], c[31:24]);
        end
        i++;
      end
    end
  endtask

  // index 3 must leave the registers untouched
  task automatic test_unused_index();
    drain();
    cfg_we <= 1'b1;
    cfg_index <= 2'd3;
    cfg_data <= $urandom;
    @(posedge clk);
    cfg_we <= 1'b0;
    repeat (20) send_random_color();
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    {in_red, in_green, in_blue, in_alpha} = '0;
    low_q = 32'h0;
    high_q = 32'hFFFFFFFF;
    minlen_q = 18'd0;
    errors = 0;
    checked = 0;
    sent = 0;
    seg_count = 0;
    cycles = 0;
    idle_on = 1'b1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_unused_index();
    test_random_segments(700);
    idle_on = 1'b0;
    test_random_segments(200);
    drain();
    $display("%0d requests sent, %0d results checked over %0d random segments",
             sent, checked, seg_count);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

>>> files.f
design/csp_pkg.sv
design/csp_lane.sv
design/csp_div.sv
design/csp_sqrt.sv
design/color_segment_projection.sv
dv/testbench.sv
